### rtl/core/assert_macros.svh
// Assertion helpers for the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside reset.
`define PMC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define PMC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/pmc_pkg.sv
package pmc_pkg;

	// Field widths
	localparam int POS_W   = 24;
	localparam int QUAT_W  = 16;
	localparam int SPEED_W = 25;
	localparam int TURN_W  = 24;
	localparam int CONF_W  = 17;
	localparam int CFG_W   = 24;

	// Action codes
	localparam logic [1:0] ACT_UPDATE = 2'd0;
	localparam logic [1:0] ACT_STORE  = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;

	// Register indexes
	localparam logic REG_MAX_TRANS = 1'b0;
	localparam logic REG_MAX_ROT   = 1'b1;

	localparam logic [CFG_W-1:0] MAX_TRANS_RST = 24'd6554;
	localparam logic [CFG_W-1:0] MAX_ROT_RST   = 24'd983040;
	localparam logic [QUAT_W-1:0] QUAT_ONE     = 16'sd16384;

	localparam logic [CONF_W-1:0] ONE_Q16        = 17'd65536;
	localparam logic [20:0]       RELIABLE_LIMIT = 21'd393216;

	// Square root unit: 52-bit radicand, one result bit per cycle
	localparam int SQ_IN_W  = 52;
	localparam int SQ_OUT_W = 26;

	// Divider: 40-bit dividend, 24-bit divisor, one quotient bit per cycle
	localparam int DV_NUM_W = 40;
	localparam int DV_DEN_W = 24;

	// CORDIC
	localparam int COR_STEPS = 24;
	localparam int COR_W     = 30;
	localparam int ANG_W     = 27;
	localparam logic [ANG_W-1:0] HALF_MAX = 27'd94371840;

	// Quaternion product accumulators (Q4.28 sums)
	localparam int QACC_W = 33;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TSQ,
		ST_TRT,
		ST_TRT_W,
		ST_QMUL,
		ST_VSQ,
		ST_VRT,
		ST_VRT_W,
		ST_COR,
		ST_COR_W,
		ST_UPD,
		ST_DIV,
		ST_DIV_W,
		ST_DONE
	} st_t;

	// One term of the relative quaternion product
	typedef struct packed {
		logic [1:0] a;    // component of the new pose
		logic [1:0] b;    // component of the reference pose
		logic       neg;
	} qterm_t;

	// Terms grouped by four: w, then the three vector parts
	function automatic qterm_t qterm(input logic [3:0] k);
		qterm_t t;
		case (k)
			4'd0:  t = '{2'd0, 2'd0, 1'b0};
			4'd1:  t = '{2'd1, 2'd1, 1'b0};
			4'd2:  t = '{2'd2, 2'd2, 1'b0};
			4'd3:  t = '{2'd3, 2'd3, 1'b0};
			4'd4:  t = '{2'd1, 2'd0, 1'b0};
			4'd5:  t = '{2'd0, 2'd1, 1'b1};
			4'd6:  t = '{2'd2, 2'd3, 1'b1};
			4'd7:  t = '{2'd3, 2'd2, 1'b0};
			4'd8:  t = '{2'd2, 2'd0, 1'b0};
			4'd9:  t = '{2'd0, 2'd2, 1'b1};
			4'd10: t = '{2'd3, 2'd1, 1'b1};
			4'd11: t = '{2'd1, 2'd3, 1'b0};
			4'd12: t = '{2'd3, 2'd0, 1'b0};
			4'd13: t = '{2'd0, 2'd3, 1'b1};
			4'd14: t = '{2'd1, 2'd2, 1'b1};
			default: t = '{2'd2, 2'd1, 1'b0};
		endcase
		return t;
	endfunction

	// Arctangent of 2^-i in Q.20 degrees
	function automatic logic [ANG_W-1:0] atan_q20(input logic [4:0] i);
		logic [ANG_W-1:0] a;
		case (i)
			5'd0:  a = 27'd47185920;
			5'd1:  a = 27'd27855475;
			5'd2:  a = 27'd14718068;
			5'd3:  a = 27'd7471121;
			5'd4:  a = 27'd3750058;
			5'd5:  a = 27'd1876857;
			5'd6:  a = 27'd938658;
			5'd7:  a = 27'd469357;
			5'd8:  a = 27'd234682;
			5'd9:  a = 27'd117342;
			5'd10: a = 27'd58671;
			5'd11: a = 27'd29335;
			5'd12: a = 27'd14668;
			5'd13: a = 27'd7334;
			5'd14: a = 27'd3667;
			5'd15: a = 27'd1833;
			5'd16: a = 27'd917;
			5'd17: a = 27'd458;
			5'd18: a = 27'd229;
			5'd19: a = 27'd115;
			5'd20: a = 27'd57;
			5'd21: a = 27'd29;
			5'd22: a = 27'd14;
			5'd23: a = 27'd7;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

### rtl/core/pmc_sqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle
module pmc_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pmc_pkg::SQ_IN_W-1:0]   operand,
	output logic                          done,
	output logic [pmc_pkg::SQ_OUT_W-1:0]  root
);
	import pmc_pkg::*;

	localparam int REM_W = SQ_OUT_W + 3;

	logic [SQ_IN_W-1:0]  opnd_q;
	logic [REM_W-1:0]    rem_q;
	logic [SQ_OUT_W-1:0] root_q;
	logic [4:0]          cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [REM_W-1:0]    rem_sh;
	logic [REM_W-1:0]    trial;
	logic                ge;

	// next remainder and trial subtrahend
	assign rem_sh = {rem_q[REM_W-3:0], opnd_q[SQ_IN_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign ge     = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			opnd_q <= '0;
			rem_q  <= '0;
			root_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
			opnd_q <= operand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			opnd_q <= {opnd_q[SQ_IN_W-3:0], 2'b00};
			rem_q  <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[SQ_OUT_W-2:0], ge};
			cnt_q  <= cnt_q + 5'd1;
			if (cnt_q == 5'(SQ_OUT_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

### rtl/core/pmc_div.sv
// Restoring divider, one quotient bit per cycle
module pmc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pmc_pkg::DV_NUM_W-1:0]  num,
	input  logic [pmc_pkg::DV_DEN_W-1:0]  den,
	output logic                          done,
	output logic [pmc_pkg::DV_NUM_W-1:0]  quo
);
	import pmc_pkg::*;

	logic [DV_NUM_W-1:0] num_q;
	logic [DV_NUM_W-1:0] quo_q;
	logic [DV_DEN_W-1:0] den_q;
	logic [DV_DEN_W-1:0] rem_q;
	logic [5:0]          cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [DV_DEN_W:0]   r2;
	logic [DV_DEN_W:0]   diff;
	logic                ge;

	// shift in the next dividend bit and try the subtraction
	assign r2   = {rem_q, num_q[DV_NUM_W-1]};
	assign diff = r2 - {1'b0, den_q};
	assign ge   = (r2 >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			quo_q  <= '0;
			den_q  <= '0;
			rem_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DV_NUM_W-2:0], 1'b0};
			rem_q <= ge ? diff[DV_DEN_W-1:0] : r2[DV_DEN_W-1:0];
			quo_q <= {quo_q[DV_NUM_W-2:0], ge};
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'(DV_NUM_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

### rtl/core/pmc_cordic.sv
// Vectoring CORDIC for the half angle atan2(y, x), one iteration per cycle,
// then clamp and scale to the full rotation step in Q8.16 degrees
module pmc_cordic (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [24:0]                   x_in,
	input  logic [pmc_pkg::SQ_OUT_W-1:0]  y_in,
	output logic                          done,
	output logic [pmc_pkg::TURN_W-1:0]    turn
);
	import pmc_pkg::*;

	logic signed [COR_W-1:0] x_q, y_q, dx, dy;
	logic signed [COR_W-1:0] z_q;
	logic signed [COR_W-1:0] ang;
	logic [4:0]              i_q;
	logic                    busy_q;
	logic                    done_q;
	logic                    zero_q;
	logic [ANG_W-1:0]        zc;
	logic [ANG_W:0]          twice;

	assign dx  = y_q >>> i_q;
	assign dy  = x_q >>> i_q;
	assign ang = COR_W'(atan_q20(i_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			zero_q <= 1'b0;
			i_q    <= '0;
			x_q    <= '0;
			y_q    <= '0;
			z_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			zero_q <= (x_in == '0) && (y_in == '0);
			i_q    <= '0;
			x_q    <= COR_W'(x_in);
			y_q    <= COR_W'(y_in);
			z_q    <= '0;
		end else if (busy_q) begin
			if (y_q > 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + ang;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - ang;
			end
			i_q <= i_q + 5'd1;
			if (i_q == 5'(COR_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// clamp to [0, 90] degrees, then (2z + 8) >> 4
	always_comb begin
		if (z_q < 0 || zero_q) begin
			zc = '0;
		end else if (z_q > COR_W'(HALF_MAX)) begin
			zc = HALF_MAX;
		end else begin
			zc = z_q[ANG_W-1:0];
		end
		twice = {zc, 1'b0} + (ANG_W+1)'(8);
	end

	assign turn = twice[ANG_W:4];
	assign done = done_q;

endmodule

### rtl/core/pose_motion_confidence.sv
// Pose motion confidence.
// Input channel (in_valid / in_stall) takes one request: an action code and
// a pose (translation Q8.16, quaternion Q1.14). Update measures the step from
// the reference pose, pushes it into the WINDOW-deep rings and makes the pose
// the new reference; store only sets the reference; clear empties the rings.
// Every request gives one result on the output channel (out_valid /
// out_stall): window averages, confidences, the reliable flag, newest steps.
// Requests are worked one at a time; in_stall is high while one is in work.
// For update the squarer, square root, quaternion product, squarer again,
// square root again and CORDIC run before the four divisions, the other
// actions go straight to them; square root unit and divider are shared.
// A finished result waits in the output register while out_stall is high;
// a new request is taken meanwhile and holds at its end until the output
// register is free. Reset empties the rings, sets the reference pose to the
// origin with identity rotation and loads the default clamp registers.
// User writes config (cfg_we, cfg_index, cfg_data) only while idle; not enforced.
module pose_motion_confidence #(
	parameter int WINDOW = 5
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          action,
	input  logic signed [pmc_pkg::POS_W-1:0]    pose_tx,
	input  logic signed [pmc_pkg::POS_W-1:0]    pose_ty,
	input  logic signed [pmc_pkg::POS_W-1:0]    pose_tz,
	input  logic signed [pmc_pkg::QUAT_W-1:0]   quat_w,
	input  logic signed [pmc_pkg::QUAT_W-1:0]   quat_x,
	input  logic signed [pmc_pkg::QUAT_W-1:0]   quat_y,
	input  logic signed [pmc_pkg::QUAT_W-1:0]   quat_z,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [pmc_pkg::SPEED_W-1:0]         avg_speed,
	output logic [pmc_pkg::TURN_W-1:0]          avg_turn,
	output logic [pmc_pkg::CONF_W-1:0]          trans_confidence,
	output logic [pmc_pkg::CONF_W-1:0]          rot_confidence,
	output logic                                reliable,
	output logic [pmc_pkg::SPEED_W-1:0]         last_speed,
	output logic [pmc_pkg::TURN_W-1:0]          last_turn,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [pmc_pkg::CFG_W-1:0]           cfg_data
);
	import pmc_pkg::*;

	localparam int PW    = $clog2(WINDOW);
	localparam int STOT_W = SPEED_W + PW;
	localparam int TTOT_W = TURN_W + PW;

	st_t state_q, state_d;
	logic [4:0] cnt_q;

	// config
	logic [CFG_W-1:0] max_trans_q, max_rot_q;

	// captured request
	logic [1:0]               act_q;
	logic signed [POS_W-1:0]  tin_q [3];
	logic signed [QUAT_W-1:0] qin_q [4];

	// reference pose
	logic signed [POS_W-1:0]  ref_t_q [3];
	logic signed [QUAT_W-1:0] ref_q_q [4];

	// rings
	logic [SPEED_W-1:0] speed_ring_q [WINDOW];
	logic [TURN_W-1:0]  turn_ring_q  [WINDOW];
	logic [WINDOW-1:0]  ring_vld_q;
	logic [PW-1:0]      ring_pos_q;
	logic [STOT_W-1:0]  speed_total_q;
	logic [TTOT_W-1:0]  turn_total_q;
	logic [SPEED_W-1:0] last_speed_q;
	logic [TURN_W-1:0]  last_turn_q;

	// steps of the current request
	logic [SPEED_W-1:0] speed_q;
	logic [TURN_W-1:0]  turn_q;

	// squarer
	logic [SPEED_W-1:0]     sq_op;
	logic [2*SPEED_W-1:0]   sq_prod_s1;
	logic                   sq_v_s1;
	logic [SQ_IN_W-1:0]     sq_acc_q;
	logic signed [POS_W:0]  tdiff;
	logic [QACC_W-1:0]      vmag;
	logic [1:0]             vidx;

	// quaternion product
	logic signed [QACC_W-1:0]     qacc_q [4];
	logic signed [2*QUAT_W-1:0]   m_prod_s1;
	logic                         m_neg_s1;
	logic [1:0]                   m_idx_s1;
	logic                         m_v_s1;
	qterm_t                       qt;
	logic [QACC_W-1:0]            wmag;

	// units
	logic                 sqrt_start, sqrt_done;
	logic [SQ_OUT_W-1:0]  sqrt_root;
	logic                 cor_start, cor_done;
	logic [TURN_W-1:0]    cor_turn;
	logic                 div_start, div_done;
	logic [DV_NUM_W-1:0]  div_num, div_quo;
	logic [DV_DEN_W-1:0]  div_den;
	logic [1:0]           dsel_q;

	// results
	logic [SPEED_W-1:0] avg_s_q;
	logic [TURN_W-1:0]  avg_t_q;
	logic [CONF_W-1:0]  tc_q, rc_q;
	logic [CFG_W-1:0]   mt, mr, at, ar;
	logic [CONF_W:0]    csum;
	logic [20:0]        csum5;
	logic               in_acc, out_free;

	// output register
	logic               out_valid_q;
	logic [SPEED_W-1:0] avg_speed_q, last_speed_oq;
	logic [TURN_W-1:0]  avg_turn_q, last_turn_oq;
	logic [CONF_W-1:0]  tconf_q, rconf_q;
	logic               reliable_q;

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_acc) state_d = (action == ACT_UPDATE) ? ST_TSQ : ST_UPD;
			ST_TSQ:   if (cnt_q == 5'd3) state_d = ST_TRT;
			ST_TRT:   state_d = ST_TRT_W;
			ST_TRT_W: if (sqrt_done) state_d = ST_QMUL;
			ST_QMUL:  if (cnt_q == 5'd16) state_d = ST_VSQ;
			ST_VSQ:   if (cnt_q == 5'd3) state_d = ST_VRT;
			ST_VRT:   state_d = ST_VRT_W;
			ST_VRT_W: if (sqrt_done) state_d = ST_COR;
			ST_COR:   state_d = ST_COR_W;
			ST_COR_W: if (cor_done) state_d = ST_UPD;
			ST_UPD:   state_d = ST_DIV;
			ST_DIV:   state_d = ST_DIV_W;
			ST_DIV_W: if (div_done) state_d = (dsel_q == 2'd3) ? ST_DONE : ST_DIV;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// unit starts
	always_comb begin
		sqrt_start = 1'b0;
		cor_start  = 1'b0;
		div_start  = 1'b0;
		case (state_q)
			ST_TRT, ST_VRT: sqrt_start = 1'b1;
			ST_COR:         cor_start  = 1'b1;
			ST_DIV:         div_start  = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? 5'd0 : cnt_q + 5'd1;
		end
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_trans_q <= MAX_TRANS_RST;
			max_rot_q   <= MAX_ROT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_TRANS: max_trans_q <= cfg_data;
				REG_MAX_ROT:   max_rot_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q    <= action;
			tin_q[0] <= pose_tx;
			tin_q[1] <= pose_ty;
			tin_q[2] <= pose_tz;
			qin_q[0] <= quat_w;
			qin_q[1] <= quat_x;
			qin_q[2] <= quat_y;
			qin_q[3] <= quat_z;
		end
	end

	// squarer operand: translation differences, then vector parts >> 8
	assign vidx  = cnt_q[1:0] + 2'd1;
	assign tdiff = (POS_W+1)'(tin_q[cnt_q[1:0]]) - (POS_W+1)'(ref_t_q[cnt_q[1:0]]);
	assign vmag  = qacc_q[vidx][QACC_W-1] ? QACC_W'(-qacc_q[vidx]) : QACC_W'(qacc_q[vidx]);
	always_comb begin
		if (state_q == ST_TSQ) begin
			sq_op = tdiff[POS_W] ? SPEED_W'(-tdiff) : SPEED_W'(tdiff);
		end else begin
			sq_op = vmag[QACC_W-1:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s1 <= 1'b0;
		end else begin
			sq_v_s1 <= (state_q == ST_TSQ || state_q == ST_VSQ) && (cnt_q < 5'd3);
		end
	end

	always_ff @(posedge clk) begin
		sq_prod_s1 <= sq_op * sq_op;
		if ((state_q == ST_TSQ || state_q == ST_VSQ) && cnt_q == 5'd0) begin
			sq_acc_q <= '0;
		end else if (sq_v_s1) begin
			sq_acc_q <= sq_acc_q + SQ_IN_W'(sq_prod_s1);
		end
	end

	// quaternion product, one term per cycle
	assign qt = qterm(cnt_q[3:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_v_s1 <= 1'b0;
		end else begin
			m_v_s1 <= (state_q == ST_QMUL) && (cnt_q < 5'd16);
		end
	end

	always_ff @(posedge clk) begin
		m_prod_s1 <= qin_q[qt.a] * ref_q_q[qt.b];
		m_neg_s1  <= qt.neg;
		m_idx_s1  <= cnt_q[3:2];
		if (state_q == ST_QMUL && cnt_q == 5'd0) begin
			for (int k = 0; k < 4; k++) qacc_q[k] <= '0;
		end else if (m_v_s1) begin
			if (m_neg_s1) qacc_q[m_idx_s1] <= qacc_q[m_idx_s1] - QACC_W'(m_prod_s1);
			else          qacc_q[m_idx_s1] <= qacc_q[m_idx_s1] + QACC_W'(m_prod_s1);
		end
	end

	assign wmag = qacc_q[0][QACC_W-1] ? QACC_W'(-qacc_q[0]) : QACC_W'(qacc_q[0]);

	pmc_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sqrt_start),
		.operand (sq_acc_q),
		.done    (sqrt_done),
		.root    (sqrt_root)
	);

	pmc_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.x_in   (wmag[QACC_W-1:8]),
		.y_in   (sqrt_root),
		.done   (cor_done),
		.turn   (cor_turn)
	);

	// step capture
	always_ff @(posedge clk) begin
		if (state_q == ST_TRT_W && sqrt_done) begin
			speed_q <= sqrt_root[SQ_OUT_W-1] ? '1 : sqrt_root[SPEED_W-1:0];
		end
		if (state_q == ST_COR_W && cor_done) begin
			turn_q <= cor_turn;
		end
	end

	// ring payload
	always_ff @(posedge clk) begin
		if (state_q == ST_UPD && act_q == ACT_UPDATE) begin
			speed_ring_q[ring_pos_q] <= speed_q;
			turn_ring_q[ring_pos_q]  <= turn_q;
		end
	end

	// ring control, totals and reference pose
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_vld_q    <= '0;
			ring_pos_q    <= '0;
			speed_total_q <= '0;
			turn_total_q  <= '0;
			last_speed_q  <= '0;
			last_turn_q   <= '0;
			for (int k = 0; k < 3; k++) ref_t_q[k] <= '0;
			ref_q_q[0] <= QUAT_ONE;
			for (int k = 1; k < 4; k++) ref_q_q[k] <= '0;
		end else if (state_q == ST_UPD) begin
			if (act_q == ACT_UPDATE) begin
				speed_total_q <= speed_total_q + STOT_W'(speed_q)
					- (ring_vld_q[ring_pos_q] ? STOT_W'(speed_ring_q[ring_pos_q]) : '0);
				turn_total_q <= turn_total_q + TTOT_W'(turn_q)
					- (ring_vld_q[ring_pos_q] ? TTOT_W'(turn_ring_q[ring_pos_q]) : '0);
				ring_vld_q[ring_pos_q] <= 1'b1;
				ring_pos_q   <= (ring_pos_q == PW'(WINDOW - 1)) ? '0 : ring_pos_q + PW'(1);
				last_speed_q <= speed_q;
				last_turn_q  <= turn_q;
			end
			if (act_q == ACT_UPDATE || act_q == ACT_STORE) begin
				for (int k = 0; k < 3; k++) ref_t_q[k] <= tin_q[k];
				for (int k = 0; k < 4; k++) ref_q_q[k] <= qin_q[k];
			end
			if (act_q == ACT_CLEAR) begin
				ring_vld_q    <= '0;
				ring_pos_q    <= '0;
				speed_total_q <= '0;
				turn_total_q  <= '0;
				last_speed_q  <= '0;
				last_turn_q   <= '0;
			end
		end
	end

	// divider operands: two averages, then two confidences
	assign mt = (max_trans_q == '0) ? CFG_W'(1) : max_trans_q;
	assign mr = (max_rot_q == '0) ? CFG_W'(1) : max_rot_q;
	assign at = (SPEED_W'(mt) < avg_s_q) ? mt : avg_s_q[CFG_W-1:0];
	assign ar = (mr < avg_t_q) ? mr : avg_t_q;

	always_comb begin
		case (dsel_q)
			2'd0: begin
				div_num = DV_NUM_W'(speed_total_q);
				div_den = DV_DEN_W'(WINDOW);
			end
			2'd1: begin
				div_num = DV_NUM_W'(turn_total_q);
				div_den = DV_DEN_W'(WINDOW);
			end
			2'd2: begin
				div_num = {at, 16'd0};
				div_den = mt;
			end
			default: begin
				div_num = {ar, 16'd0};
				div_den = mr;
			end
		endcase
	end

	pmc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dsel_q <= '0;
		end else if (state_q == ST_UPD) begin
			dsel_q <= '0;
		end else if (state_q == ST_DIV_W && div_done) begin
			dsel_q <= dsel_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DIV_W && div_done) begin
			case (dsel_q)
				2'd0: avg_s_q <= div_quo[SPEED_W-1:0];
				2'd1: avg_t_q <= div_quo[TURN_W-1:0];
				2'd2: tc_q    <= ONE_Q16 - div_quo[CONF_W-1:0];
				default: rc_q <= ONE_Q16 - div_quo[CONF_W-1:0];
			endcase
		end
	end

	// mean of the confidences above 0.6
	assign csum  = {1'b0, tc_q} + {1'b0, rc_q};
	assign csum5 = (21'(csum) << 2) + 21'(csum);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			avg_speed_q   <= avg_s_q;
			avg_turn_q    <= avg_t_q;
			tconf_q       <= tc_q;
			rconf_q       <= rc_q;
			reliable_q    <= (csum5 > RELIABLE_LIMIT);
			last_speed_oq <= last_speed_q;
			last_turn_oq  <= last_turn_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign avg_speed        = avg_speed_q;
	assign avg_turn         = avg_turn_q;
	assign trans_confidence = tconf_q;
	assign rot_confidence   = rconf_q;
	assign reliable         = reliable_q;
	assign last_speed       = last_speed_oq;
	assign last_turn        = last_turn_oq;

endmodule

### rtl/core/pmc_checker.sv
`include "assert_macros.svh"

// Port-level checks on the pose motion confidence block
module pmc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic [pmc_pkg::SPEED_W-1:0]         avg_speed,
	input logic [pmc_pkg::CONF_W-1:0]          trans_confidence,
	input logic [pmc_pkg::CONF_W-1:0]          rot_confidence,
	input logic                                reliable
);
	import pmc_pkg::*;

	// a stalled result holds
	`PMC_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(avg_speed), "result dropped or changed under stall")

	// one request at a time: after an accept the input stalls
	`PMC_ASSERT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall |=> in_stall, "second request taken while busy")

	// a new result only comes out of a request in work
	`PMC_ASSERT(a_result_from_work, clk, arst_n, $rose(out_valid) |-> $past(in_stall), "result without a request")

	// reliable flag agrees with the confidences
	`PMC_ASSERT(a_reliable, clk, arst_n, out_valid |-> (reliable == (((32'(trans_confidence) + 32'(rot_confidence)) * 32'd5) > 32'd393216)), "reliable flag mismatch")

	// no result follows a sampled reset
	`PMC_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |=> !out_valid, "result during reset")

endmodule

bind pose_motion_confidence pmc_checker u_pmc_checker (.*);

### test/tb_top.sv
`timescale 1ns / 100ps

import pmc_pkg::*;

// one request as driven on the input channel
typedef struct {
	logic [1:0]         action;
	logic signed [23:0] tx, ty, tz;
	logic signed [15:0] qw, qx, qy, qz;
} pose_req_t;

// one result as seen on the output channel
typedef struct packed {
	logic [24:0] avg_speed;
	logic [23:0] avg_turn;
	logic [16:0] trans_conf;
	logic [16:0] rot_conf;
	logic        reliable;
	logic [24:0] last_speed;
	logic [23:0] last_turn;
} motion_res_t;

class motion_scoreboard;
	localparam int DEPTH = 5;
	localparam longint SPEED_SAT = 33554431;
	localparam longint TURN_SAT = 11796480;
	localparam longint HALF_SAT = 94371840;
	localparam longint ATAN_DEG[24] = '{
		47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
		234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
		917, 458, 229, 115, 57, 29, 14, 7};

	longint clamp_trans, clamp_rot;
	longint speed_hist[DEPTH], turn_hist[DEPTH];
	int     slot;
	bit     filled;
	longint speed_sum, turn_sum;
	longint anchor_t[3], anchor_q[4];
	motion_res_t expected_q[$];
	int     mismatches, checked, updates;

	function new();
		clamp_trans = 6554;
		clamp_rot = 983040;
		foreach (speed_hist[i]) begin
			speed_hist[i] = 0;
			turn_hist[i] = 0;
		end
		slot = 0;
		filled = 0;
		speed_sum = 0;
		turn_sum = 0;
		foreach (anchor_t[i]) anchor_t[i] = 0;
		anchor_q = '{16384, 0, 0, 0};
		mismatches = 0;
		checked = 0;
		updates = 0;
	endfunction

	function void set_clamp(logic idx, longint v);
		if (idx == REG_MAX_TRANS) clamp_trans = v;
		else clamp_rot = v;
	endfunction

	function longint int_sqrt(longint n);
		longint r, b;
		r = 0;
		b = 64'sd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else r = r >> 1;
			b = b >> 2;
		end
		return r;
	endfunction

	function longint magnitude(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// CORDIC vectoring: half angle in Q.20 degrees
	function longint half_turn(longint x, longint y);
		longint z, dx, dy;
		z = 0;
		if (x == 0 && y == 0) return 0;
		for (int i = 0; i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += ATAN_DEG[i];
			end else begin
				x -= dx; y += dy; z -= ATAN_DEG[i];
			end
		end
		if (z < 0) z = 0;
		if (z > HALF_SAT) z = HALF_SAT;
		return z;
	endfunction

	function longint conf_of(longint avg, longint lim);
		if (lim == 0) lim = 1;
		if (avg > lim) avg = lim;
		return 65536 - ((avg << 16) / lim);
	endfunction

	// accepted request: advance state, queue the expected result
	function void note_request(pose_req_t r);
		longint t[3], q[4], ss, vs, speed, turn, dw, dv[3], c, tc, rc;
		int lp;
		motion_res_t e;
		t = '{r.tx, r.ty, r.tz};
		q = '{r.qw, r.qx, r.qy, r.qz};
		if (r.action == ACT_UPDATE) begin
			updates++;
			ss = 0;
			for (int i = 0; i < 3; i++) ss += (t[i] - anchor_t[i]) * (t[i] - anchor_t[i]);
			speed = int_sqrt(ss);
			if (speed > SPEED_SAT) speed = SPEED_SAT;
			// q_new * conj(q_ref)
			dw = q[0]*anchor_q[0] + q[1]*anchor_q[1] + q[2]*anchor_q[2] + q[3]*anchor_q[3];
			dv[0] = anchor_q[0]*q[1] - q[0]*anchor_q[1] - (q[2]*anchor_q[3] - q[3]*anchor_q[2]);
			dv[1] = anchor_q[0]*q[2] - q[0]*anchor_q[2] - (q[3]*anchor_q[1] - q[1]*anchor_q[3]);
			dv[2] = anchor_q[0]*q[3] - q[0]*anchor_q[3] - (q[1]*anchor_q[2] - q[2]*anchor_q[1]);
			vs = 0;
			for (int i = 0; i < 3; i++) begin
				c = magnitude(dv[i]) >> 8;
				vs += c * c;
			end
			turn = (half_turn(magnitude(dw) >> 8, int_sqrt(vs)) * 2 + 8) >> 4;
			if (turn > TURN_SAT) turn = TURN_SAT;
			speed_sum = speed_sum - speed_hist[slot] + speed;
			turn_sum = turn_sum - turn_hist[slot] + turn;
			speed_hist[slot] = speed;
			turn_hist[slot] = turn;
			slot = (slot + 1 >= DEPTH) ? 0 : slot + 1;
			filled = 1;
		end
		if (r.action == ACT_UPDATE || r.action == ACT_STORE) begin
			anchor_t = t;
			anchor_q = q;
		end else if (r.action == ACT_CLEAR) begin
			foreach (speed_hist[i]) begin
				speed_hist[i] = 0;
				turn_hist[i] = 0;
			end
			slot = 0;
			filled = 0;
			speed_sum = 0;
			turn_sum = 0;
		end
		e.avg_speed = 25'(speed_sum / DEPTH);
		e.avg_turn = 24'(turn_sum / DEPTH);
		tc = conf_of(speed_sum / DEPTH, clamp_trans);
		rc = conf_of(turn_sum / DEPTH, clamp_rot);
		e.trans_conf = 17'(tc);
		e.rot_conf = 17'(rc);
		e.reliable = (5 * (tc + rc) > 6 * 65536);
		lp = (slot == 0) ? DEPTH - 1 : slot - 1;
		e.last_speed = filled ? 25'(speed_hist[lp]) : '0;
		e.last_turn = filled ? 24'(turn_hist[lp]) : '0;
		expected_q = {expected_q, e};
	endfunction

	function void check_result(motion_res_t a);
		motion_res_t e;
		checked++;
		if (expected_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("ERROR: result with nothing expected");
			return;
		end
		e = expected_q.pop_front();
		if (a !== e) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("ERROR: result %0d differs", checked);
				$display("  exp spd %0d trn %0d tc %0d rc %0d rel %0d ls %0d lt %0d",
					e.avg_speed, e.avg_turn, e.trans_conf, e.rot_conf, e.reliable,
					e.last_speed, e.last_turn);
				$display("  got spd %0d trn %0d tc %0d rc %0d rel %0d ls %0d lt %0d",
					a.avg_speed, a.avg_turn, a.trans_conf, a.rot_conf, a.reliable,
					a.last_speed, a.last_turn);
			end
		end
	endfunction
endclass

module tb_top;
	localparam int STALL_LIMIT = 4000;
	localparam int LONG_HOLD = 700;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] action = ACT_UPDATE;
	logic signed [23:0] pose_tx = '0, pose_ty = '0, pose_tz = '0;
	logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [24:0] avg_speed, last_speed;
	logic [23:0] avg_turn, last_turn;
	logic [16:0] trans_confidence, rot_confidence;
	logic reliable;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_MAX_TRANS;
	logic [23:0] cfg_data = '0;

	motion_scoreboard sb = new();
	int idle_cycles = 0;
	bit quiet = 0;          // no idling on either side
	bit hold_req = 0;       // ask receiver for one long hold
	int sent = 0, cfg_writes = 0;
	pose_req_t prev;

	always #5 clk = ~clk;

	pose_motion_confidence i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .action(action),
		.pose_tx(pose_tx), .pose_ty(pose_ty), .pose_tz(pose_tz),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.avg_speed(avg_speed), .avg_turn(avg_turn),
		.trans_confidence(trans_confidence), .rot_confidence(rot_confidence),
		.reliable(reliable), .last_speed(last_speed), .last_turn(last_turn),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// channel monitor and watchdog
	always @(posedge clk) begin
		pose_req_t r;
		motion_res_t a;
		bit moved;
		moved = 0;
		if (arst_n && in_valid && !in_stall) begin
			r = '{action, pose_tx, pose_ty, pose_tz, quat_w, quat_x, quat_y, quat_z};
			sb.note_request(r);
			moved = 1;
		end
		if (arst_n && out_valid && !out_stall) begin
			a = '{avg_speed, avg_turn, trans_confidence, rot_confidence, reliable,
				last_speed, last_turn};
			sb.check_result(a);
			moved = 1;
		end
		idle_cycles = moved ? 0 : idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				out_stall <= 1'b0;
				hold_req = 0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_request(pose_req_t r);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		action <= r.action;
		{pose_tx, pose_ty, pose_tz} <= {r.tx, r.ty, r.tz};
		{quat_w, quat_x, quat_y, quat_z} <= {r.qw, r.qx, r.qy, r.qz};
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		sent++;
		prev = r;
	endtask

	// drain, then write a clamp register while idle
	task automatic write_clamp(logic idx, logic [23:0] v);
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (5) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_clamp(idx, v);
		cfg_writes++;
	endtask

	function automatic logic signed [15:0] quat_full();
		return 16'(int'($urandom_range(0, 32768)) - 16384);
	endfunction

	function automatic logic signed [23:0] near(logic signed [23:0] p);
		longint v;
		v = longint'(p) + int'($urandom_range(0, 16000)) - 8000;
		if (v > 8388607) v = 8388607;
		if (v < -8388608) v = -8388608;
		return 24'(v);
	endfunction

	// mostly smooth camera motion, some jumps and odd actions
	function automatic pose_req_t random_request();
		pose_req_t r;
		int sel, pick;
		sel = $urandom_range(0, 99);
		r.action = (sel < 82) ? ACT_UPDATE : (sel < 90) ? ACT_STORE :
			(sel < 96) ? ACT_CLEAR : 2'd3;
		pick = $urandom_range(0, 9);
		if (pick < 7) begin
			r.tx = near(prev.tx);
			r.ty = near(prev.ty);
			r.tz = near(prev.tz);
			r.qw = 16'($urandom_range(12000, 16384));
			if ($urandom_range(0, 3) == 0) r.qw = -r.qw;
			r.qx = 16'(int'($urandom_range(0, 6000)) - 3000);
			r.qy = 16'(int'($urandom_range(0, 6000)) - 3000);
			r.qz = 16'(int'($urandom_range(0, 6000)) - 3000);
		end else begin
			r.tx = 24'($urandom);
			r.ty = 24'($urandom);
			r.tz = 24'($urandom);
			r.qw = quat_full();
			r.qx = quat_full();
			r.qy = quat_full();
			r.qz = quat_full();
		end
		return r;
	endfunction

	task automatic random_phase(int n);
		repeat (n) send_request(random_request());
	endtask

	initial begin
		prev = '{ACT_UPDATE, 0, 0, 0, 16384, 0, 0, 0};
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: extremes, every action, corner rotations
		send_request('{ACT_UPDATE, 0, 0, 0, 16384, 0, 0, 0});
		send_request('{ACT_UPDATE, 24'sd8388607, 24'sd8388607, 24'sd8388607, 16384, 0, 0, 0});
		send_request('{ACT_UPDATE, -24'sd8388608, -24'sd8388608, -24'sd8388608,
			-16384, 0, 0, 0});
		send_request('{ACT_UPDATE, 0, 0, 0, 0, 16384, 0, 0});
		send_request('{ACT_UPDATE, 0, 0, 0, 0, 0, 0, 0});
		send_request('{ACT_UPDATE, 0, 0, 0, 0, 0, 0, 0});
		send_request('{ACT_UPDATE, 100, -100, 50, 16384, 16384, 16384, 16384});
		send_request('{ACT_UPDATE, 200, 0, 0, -16384, -16384, -16384, -16384});
		send_request('{ACT_UPDATE, 300, 0, 0, 8000, 0, 0, 0});
		send_request('{ACT_STORE, 24'sd8388607, 0, -24'sd8388608, 0, 0, 16384, 0});
		send_request('{ACT_UPDATE, 24'sd8388607, 0, -24'sd8388608, 0, 0, 16384, 0});
		send_request('{2'd3, 1, 2, 3, 4, 5, 6, 7});
		send_request('{ACT_UPDATE, 1000, 1000, 1000, 16000, 3000, 0, 0});
		send_request('{ACT_UPDATE, 2000, 1000, 1000, 16000, 0, 3000, 0});
		send_request('{ACT_UPDATE, 3000, 1000, 1000, 16000, 0, 0, 3000});
		send_request('{ACT_UPDATE, 3001, 1000, 1000, 16000, 0, 0, 3001});
		send_request('{ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0});
		send_request('{ACT_UPDATE, 3001, 1000, 1000, 16000, 0, 0, 3001});
		send_request('{ACT_CLEAR, 5, 5, 5, 5, 5, 5, 5});
		send_request('{2'd3, 0, 0, 0, 0, 0, 0, 0});

		// settings sweep, extremes included
		write_clamp(REG_MAX_TRANS, 24'd0);
		write_clamp(REG_MAX_ROT, 24'd0);
		random_phase(120);
		write_clamp(REG_MAX_TRANS, 24'hFFFFFF);
		write_clamp(REG_MAX_ROT, 24'd11796480);
		random_phase(120);
		write_clamp(REG_MAX_TRANS, 24'd1);
		write_clamp(REG_MAX_ROT, 24'd1);
		random_phase(120);
		write_clamp(REG_MAX_TRANS, 24'd6554);
		write_clamp(REG_MAX_ROT, 24'd983040);

		// long receiver hold while requests keep coming
		hold_req = 1;
		random_phase(150);
		write_clamp(REG_MAX_TRANS, 24'($urandom_range(1000, 200000)));
		write_clamp(REG_MAX_ROT, 24'($urandom_range(65536, 4000000)));
		random_phase(200);
		write_clamp(REG_MAX_TRANS, 24'd20000);
		write_clamp(REG_MAX_ROT, 24'd300000);
		random_phase(150);

		// final stretch at full rate
		quiet = 1;
		random_phase(170);
		in_valid <= 1'b0;

		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		$display("Sent %0d requests (%0d updates), checked %0d results, %0d clamp writes",
			sent, sb.updates, sb.checked, cfg_writes);
		$display("Mismatches: %0d", sb.mismatches);
		if (sb.mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
